// File: design/arpc_pkg.sv
// Shared types and constants for the address-resolution cache.
// Used by arpc_cell and arp_cache_lru_resolver_top; depends on nothing.
`default_nettype none

package arpc_pkg;

    // Entry index as carried between cells (enough for up to 64 entries)
    localparam int IDX_W = 6;
    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int AGE_W = 32;
    localparam int CNT_OUT_W = 4;

    localparam logic [IP_W-1:0]  IP_ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [MAC_W-1:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [AGE_W-1:0] AGE_MAX      = 32'hFFFF_FFFF;

    // Request codes
    localparam logic CMD_LEARN   = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RESOLVE_ENABLE = 2'd0,
        CFG_OWN_IPV4       = 2'd1,
        CFG_SUBNET_MASK    = 2'd2,
        CFG_GATEWAY_IPV4   = 2'd3
    } cfg_idx_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic             active;
        logic [IP_W-1:0]  key;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [MAC_W-1:0] hit_mac;
        logic             free_ok;
        logic [IDX_W-1:0] free_idx;
        logic [AGE_W-1:0] old_age;
        logic [IDX_W-1:0] old_idx;
    } tok_t;

    // Write-back broadcast to all cells
    typedef struct packed {
        logic             en;
        logic             full;   // write address, MAC and valid as well as age
        logic [IDX_W-1:0] idx;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [AGE_W-1:0] age;
    } wr_t;

endpackage

`default_nettype wire

// File: design/arpc_cell.sv
// One cache entry plus one stage of the search chain.
// Depends on arpc_pkg (tok_t, wr_t).
`default_nettype none

module arpc_cell
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [arpc_pkg::IDX_W-1:0] cell_idx,
    input  wire arpc_pkg::tok_t          tok_in,
    input  wire arpc_pkg::wr_t           wr,
    output      arpc_pkg::tok_t          tok_out
);

    logic                       valid_reg;
    logic [arpc_pkg::IP_W-1:0]  ip_reg;
    logic [arpc_pkg::MAC_W-1:0] mac_reg;
    logic [arpc_pkg::AGE_W-1:0] age_reg;

    arpc_pkg::tok_t tok_reg;
    arpc_pkg::tok_t tok_next;
    logic           wr_sel;

    // Search step: first match, first free, strictly smallest age
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && !tok_in.hit)
        begin
            if (valid_reg)
            begin
                if (ip_reg == tok_in.key)
                begin
                    tok_next.hit     = 1'b1;
                    tok_next.hit_idx = cell_idx;
                    tok_next.hit_mac = mac_reg;
                end
                else if (age_reg < tok_in.old_age)
                begin
                    tok_next.old_age = age_reg;
                    tok_next.old_idx = cell_idx;
                end
            end
            else if (!tok_in.free_ok)
            begin
                tok_next.free_ok  = 1'b1;
                tok_next.free_idx = cell_idx;
            end
        end
    end

    assign wr_sel  = wr.en && (wr.idx == cell_idx);
    assign tok_out = tok_reg;

    // Token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Entry valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_sel && wr.full)
        begin
            valid_reg <= 1'b1;
        end
    end

    // Entry payload; only read once valid
    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            age_reg <= wr.age;
            if (wr.full)
            begin
                ip_reg  <= wr.ip;
                mac_reg <= wr.mac;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/arp_cache_lru_resolver_top.sv
// Address-resolution cache top level: config registers, controller, cell row.
// Depends on arpc_pkg and arpc_cell.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | into      | in_valid/in_stall  | cmd, ip_addr, mac_addr
//  out     | out of    | out_valid/out_stall| found, mac_out, hop_addr, valid_count
//  cfg     | into      | cfg_we             | cfg_index, cfg_data
//
// The search token walks one cell per cycle through the row of ENTRIES cells;
// at the tail come the write-back and the pending result register, then the
// output register, which loads once the output slot is free.
// Reset clears all entries, the age counter and the config registers at once.
// A new request is taken while a result still waits in the output register;
// the finished result then holds in S_DONE until the output slot frees.
`default_nettype none

module arp_cache_lru_resolver_top
#(
    parameter int ENTRIES = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic        cmd,
    input  wire logic [31:0] ip_addr,
    input  wire logic [47:0] mac_addr,
    // result channel
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic        found,
    output      logic [47:0] mac_out,
    output      logic [31:0] hop_addr,
    output      logic [3:0]  valid_count,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    // config registers
    logic        enable_reg;
    logic [31:0] own_ip_reg;
    logic [31:0] mask_reg;
    logic [31:0] gw_reg;

    // controller
    arpc_pkg::state_t state_reg;
    arpc_pkg::state_t state_next;
    logic             in_take;
    logic             fire;
    logic             out_load;
    logic             out_free;

    // held request
    logic        cmd_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [31:0] hop_reg;
    logic [31:0] hop_calc;

    // shared state
    logic [31:0]      age_cnt_reg;
    logic [31:0]      age_cnt_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // pending result
    logic        res_found_reg;
    logic [47:0] res_mac_reg;
    logic [31:0] res_hop_reg;
    logic [3:0]  res_cnt_reg;
    logic        res_found_next;
    logic [47:0] res_mac_next;
    logic [31:0] res_hop_next;

    // output register
    logic        out_valid_reg;
    logic        found_reg;
    logic [47:0] mac_out_reg;
    logic [31:0] hop_addr_reg;
    logic [3:0]  valid_count_reg;

    arpc_pkg::tok_t tok_chain [0:ENTRIES];
    arpc_pkg::tok_t tail;
    arpc_pkg::wr_t  wr;
    logic           fill;

    // Config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            own_ip_reg <= '0;
            mask_reg   <= '0;
            gw_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (arpc_pkg::cfg_idx_t'(cfg_index))
                arpc_pkg::CFG_RESOLVE_ENABLE: enable_reg <= cfg_data[0];
                arpc_pkg::CFG_OWN_IPV4:       own_ip_reg <= cfg_data;
                arpc_pkg::CFG_SUBNET_MASK:    mask_reg   <= cfg_data;
                arpc_pkg::CFG_GATEWAY_IPV4:   gw_reg     <= cfg_data;
                default:                      enable_reg <= enable_reg;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arpc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = arpc_pkg::S_SCAN;
                end
            end
            arpc_pkg::S_SCAN:
            begin
                if (tail.active)
                begin
                    state_next = arpc_pkg::S_DONE;
                end
            end
            arpc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = arpc_pkg::S_IDLE;
                end
            end
            default: state_next = arpc_pkg::S_IDLE;
        endcase
    end

    // Controller outputs
    always_comb
    begin
        in_stall = 1'b1;
        fire     = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            arpc_pkg::S_IDLE: in_stall = 1'b0;
            arpc_pkg::S_SCAN: fire     = tail.active;
            arpc_pkg::S_DONE: out_load = out_free;
            default:          in_stall = 1'b1;
        endcase
    end

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arpc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next hop: gateway when off-subnet and a gateway is set
    always_comb
    begin
        hop_calc = ip_addr;
        if ((((ip_addr ^ own_ip_reg) & mask_reg) != 32'd0) && (gw_reg != 32'd0))
        begin
            hop_calc = gw_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg <= cmd;
            ip_reg  <= ip_addr;
            mac_reg <= mac_addr;
            hop_reg <= hop_calc;
        end
    end

    // Token injected at the head of the row
    always_comb
    begin
        tok_chain[0]          = '0;
        tok_chain[0].active   = in_take;
        tok_chain[0].key      = (cmd == arpc_pkg::CMD_LEARN) ? ip_addr : hop_calc;
        tok_chain[0].old_age  = arpc_pkg::AGE_MAX;
    end

    // Row of cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        arpc_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (arpc_pkg::IDX_W'(i)),
            .tok_in   (tok_chain[i]),
            .wr       (wr),
            .tok_out  (tok_chain[i+1])
        );
    end

    assign tail = tok_chain[ENTRIES];

    // Decision at the tail of the row and write-back
    always_comb
    begin
        wr             = '0;
        wr.ip          = ip_reg;
        wr.mac         = mac_reg;
        wr.age         = age_cnt_reg + 32'd1;
        fill           = 1'b0;
        res_found_next = 1'b0;
        res_mac_next   = '0;
        res_hop_next   = '0;
        if (fire)
        begin
            if (cmd_reg == arpc_pkg::CMD_LEARN)
            begin
                if ((ip_reg != 32'd0) && (mac_reg != 48'd0))
                begin
                    res_found_next = 1'b1;
                    wr.en          = 1'b1;
                    wr.full        = 1'b1;
                    if (tail.hit)
                    begin
                        wr.idx = tail.hit_idx;
                    end
                    else if (tail.free_ok)
                    begin
                        wr.idx = tail.free_idx;
                        fill   = 1'b1;
                    end
                    else
                    begin
                        wr.idx = tail.old_idx;
                    end
                end
            end
            else if (enable_reg)
            begin
                if (ip_reg == arpc_pkg::IP_ALL_ONES)
                begin
                    res_found_next = 1'b1;
                    res_mac_next   = arpc_pkg::MAC_ALL_ONES;
                    res_hop_next   = arpc_pkg::IP_ALL_ONES;
                end
                else
                begin
                    res_hop_next = hop_reg;
                    if (tail.hit)
                    begin
                        res_found_next = 1'b1;
                        res_mac_next   = tail.hit_mac;
                        wr.en          = 1'b1;
                        wr.idx         = tail.hit_idx;
                    end
                end
            end
        end
    end

    assign age_cnt_next = wr.en ? wr.age : age_cnt_reg;
    assign cnt_next     = fill ? (cnt_reg + CNT_W'(1)) : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_cnt_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            age_cnt_reg <= age_cnt_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Pending result; count saturates at 15
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_found_reg <= res_found_next;
            res_mac_reg   <= res_mac_next;
            res_hop_reg   <= res_hop_next;
            if (32'(cnt_next) > 32'd15)
            begin
                res_cnt_reg <= 4'd15;
            end
            else
            begin
                res_cnt_reg <= 4'(cnt_next);
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            found_reg       <= res_found_reg;
            mac_out_reg     <= res_mac_reg;
            hop_addr_reg    <= res_hop_reg;
            valid_count_reg <= res_cnt_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign mac_out     = mac_out_reg;
    assign hop_addr    = hop_addr_reg;
    assign valid_count = valid_count_reg;

`ifndef SYNTH
    // A token leaves the row only while the controller waits for it
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> (state_reg == arpc_pkg::S_SCAN))
        else $error("search token left the row outside scan");

    // Fill count never exceeds the number of cells
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= 32'(ENTRIES))
        else $error("valid entry count beyond cache size");

    // Age counter steps by at most one per cycle
    a_age_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 ((age_cnt_reg == $past(age_cnt_reg))
            || (age_cnt_reg == ($past(age_cnt_reg) + 32'd1))))
        else $error("age counter jumped");

    // A loaded result is presented next cycle
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result load lost");
`endif

endmodule

`default_nettype wire
